>>> design/pdlrw_pkg.sv
// Package of types, constants and helpers shared by the PWM duty-level ramp writer.
package pdlrw_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 7;

   typedef enum logic [2:0] {
      CSR_MAX_FIRST   = 3'd0,
      CSR_MIN_FIRST   = 3'd1,
      CSR_MAX_SECOND  = 3'd2,
      CSR_MIN_SECOND  = 3'd3,
      CSR_INVERT      = 3'd4,
      CSR_LONG_PERIOD = 3'd5
   } csr_index_type;

   localparam logic [6:0]  DUTY_FULL   = 7'd100;
   localparam logic [6:0]  DUTY_NEAR   = 7'd99;
   localparam logic [5:0]  DUTY_HALF   = 6'd50;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

   localparam logic [7:0] CTRL_ADDR       = 8'h92;
   localparam logic [7:0] ON_ADDR_FIRST   = 8'h00;
   localparam logic [7:0] ON_ADDR_SECOND  = 8'h03;
   localparam logic [7:0] OFF_ADDR_FIRST  = 8'h01;
   localparam logic [7:0] OFF_ADDR_SECOND = 8'h04;

   localparam logic [6:0] OFF_LONG     = 7'h7F;
   localparam logic [6:0] OFF_SHORT    = 7'h3F;
   localparam logic [6:0] ON_TOP_LONG  = 7'h7E;
   localparam logic [6:0] ON_TOP_SHORT = 7'h3E;
   localparam logic [6:0] ON_BOTTOM    = 7'h01;
   localparam logic [6:0] STEP_LONG    = 7'd8;
   localparam logic [6:0] STEP_SHORT   = 7'd4;

   localparam logic [2:0] CTL_CLK = 3'b100;
   localparam logic [2:0] CTL_SET = 3'b010;
   localparam logic [2:0] CTL_RST = 3'b001;
   localparam logic [2:0] CTL_ALL = 3'b111;

   localparam logic BLK_LEVEL   = 1'b0;
   localparam logic BLK_CONTROL = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CALC1,
      OP_CALC2,
      OP_CALC3,
      OP_CALC4,
      OP_CALC5,
      OP_W_EN_OFF,
      OP_W_EN_CTL,
      OP_W_FINAL,
      OP_W_RAMP,
      OP_W_EN_SET,
      OP_W_DIS_CTL1,
      OP_W_DIS_CTL2,
      OP_W_DIS_OFF,
      OP_W_DIS_ON
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      unit_duty;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic       act;
      logic       duty_zero;
      logic       ch;
      logic [1:0] en;
      logic       count_zero;
      logic       out_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EN_OFF,
      ST_EN_CTL,
      ST_CALC1,
      ST_CALC2,
      ST_CALC3,
      ST_CALC4,
      ST_CALC5,
      ST_RAMP,
      ST_FINAL,
      ST_EN_SET,
      ST_DIS_CTL1,
      ST_DIS_CTL2,
      ST_DIS_OFF,
      ST_DIS_ON
   } ctrl_state_type;

   // Places the three control bits of a channel in the shared control image.
   function automatic logic [5:0] ctl_bits(input logic ch, input logic [2:0] bits);
      return ch ? {bits, 3'b000} : {3'b000, bits};
   endfunction

endpackage

>>> design/pwm_duty_level_ramp_writer_core.sv
// Top level of the PWM duty-level ramp writer: controller and datapath.
//
// A request transfer on the req_ channel either sets the duty percent of one
// of two PWM channels or shuts down every enabled channel. The block answers
// with the ordered register writes a driver would issue, one transfer per
// write on the rsp_ channel, the final one flagged by rsp_last_write.
// Settings are written through the csr_ port; the user must write them only
// while the block is idle, which the block itself does not enforce.
// A request is taken only while the controller is idle and decoded in the
// DISPATCH state. Each duty computation runs through the states CALC1 to
// CALC5 in a shared reciprocal multiplier. The writes leave one at a time,
// each waiting for the result register to be free. A duty change or first
// enable ends in a ramp of at most 15 steps. Results sit in an output
// register, so the next request is taken while the last write still waits;
// the sequencer holds its next write while rsp_stall is high and one waits.
// Reset returns the settings to their defaults, disables both channels,
// clears the control image and sets the held ON levels to one.
module pwm_duty_level_ramp_writer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic                              req_channel,
   input  logic [7:0]                        req_duty_percent,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_target_block,
   output logic [7:0]                        rsp_reg_address,
   output logic [7:0]                        rsp_write_data,
   output logic                              rsp_last_write,
   input  logic                              csr_write_enable,
   input  logic [pdlrw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pdlrw_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   pdlrw_pkg::dp_cmd_type    cmd;
   pdlrw_pkg::dp_status_type status;

   pdlrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pdlrw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_channel      (req_channel),
      .req_duty_percent (req_duty_percent),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_target_block (rsp_target_block),
      .rsp_reg_address  (rsp_reg_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_last_write   (rsp_last_write),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> design/pdlrw_ctrl.sv
// Sequencing state machine of the PWM duty-level ramp writer.
module pdlrw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pdlrw_pkg::dp_status_type status,
   output pdlrw_pkg::dp_cmd_type    cmd
);

   pdlrw_pkg::ctrl_state_type state_ff, state_in;
   logic                      phase_ff, phase_in;
   logic                      more_ch;
   logic                      cmd_is_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdlrw_pkg::ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign more_ch = status.act && !status.ch && status.en[1];

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cmd.op        = pdlrw_pkg::OP_NONE;
      cmd.unit_duty = phase_ff;
      cmd.last      = 1'b0;
      unique case (state_ff)
         pdlrw_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = pdlrw_pkg::OP_LOAD;
               state_in = pdlrw_pkg::ST_DISPATCH;
            end
         end
         pdlrw_pkg::ST_DISPATCH: begin
            if (status.act) begin
               state_in = (status.en != 2'b00) ? pdlrw_pkg::ST_DIS_CTL1 : pdlrw_pkg::ST_IDLE;
            end else if (status.duty_zero) begin
               state_in = pdlrw_pkg::ST_DIS_CTL1;
            end else if (status.en[status.ch]) begin
               phase_in = 1'b0;
               state_in = pdlrw_pkg::ST_CALC1;
            end else begin
               phase_in = 1'b1;
               state_in = pdlrw_pkg::ST_EN_OFF;
            end
         end
         pdlrw_pkg::ST_EN_OFF: begin
            if (status.out_free) begin
               cmd.op   = pdlrw_pkg::OP_W_EN_OFF;
               state_in = pdlrw_pkg::ST_EN_CTL;
            end
         end
         pdlrw_pkg::ST_EN_CTL: begin
            if (status.out_free) begin
               cmd.op   = pdlrw_pkg::OP_W_EN_CTL;
               state_in = pdlrw_pkg::ST_CALC1;
            end
         end
         pdlrw_pkg::ST_CALC1: begin
            cmd.op   = pdlrw_pkg::OP_CALC1;
            state_in = pdlrw_pkg::ST_CALC2;
         end
         pdlrw_pkg::ST_CALC2: begin
            cmd.op   = pdlrw_pkg::OP_CALC2;
            state_in = pdlrw_pkg::ST_CALC3;
         end
         pdlrw_pkg::ST_CALC3: begin
            cmd.op   = pdlrw_pkg::OP_CALC3;
            state_in = pdlrw_pkg::ST_CALC4;
         end
         pdlrw_pkg::ST_CALC4: begin
            cmd.op   = pdlrw_pkg::OP_CALC4;
            state_in = pdlrw_pkg::ST_CALC5;
         end
         pdlrw_pkg::ST_CALC5: begin
            cmd.op   = pdlrw_pkg::OP_CALC5;
            state_in = phase_ff ? pdlrw_pkg::ST_FINAL : pdlrw_pkg::ST_RAMP;
         end
         pdlrw_pkg::ST_RAMP: begin
            if (status.count_zero) begin
               state_in = pdlrw_pkg::ST_FINAL;
            end else if (status.out_free) begin
               cmd.op = pdlrw_pkg::OP_W_RAMP;
            end
         end
         pdlrw_pkg::ST_FINAL: begin
            if (status.out_free) begin
               cmd.op   = pdlrw_pkg::OP_W_FINAL;
               cmd.last = !phase_ff;
               state_in = phase_ff ? pdlrw_pkg::ST_EN_SET : pdlrw_pkg::ST_IDLE;
            end
         end
         pdlrw_pkg::ST_EN_SET: begin
            if (status.out_free) begin
               cmd.op   = pdlrw_pkg::OP_W_EN_SET;
               phase_in = 1'b0;
               state_in = pdlrw_pkg::ST_CALC1;
            end
         end
         pdlrw_pkg::ST_DIS_CTL1: begin
            if (status.out_free) begin
               cmd.op   = pdlrw_pkg::OP_W_DIS_CTL1;
               state_in = pdlrw_pkg::ST_DIS_CTL2;
            end
         end
         pdlrw_pkg::ST_DIS_CTL2: begin
            if (status.out_free) begin
               cmd.op   = pdlrw_pkg::OP_W_DIS_CTL2;
               state_in = pdlrw_pkg::ST_DIS_OFF;
            end
         end
         pdlrw_pkg::ST_DIS_OFF: begin
            if (status.out_free) begin
               cmd.op   = pdlrw_pkg::OP_W_DIS_OFF;
               state_in = pdlrw_pkg::ST_DIS_ON;
            end
         end
         pdlrw_pkg::ST_DIS_ON: begin
            if (status.out_free) begin
               cmd.op   = pdlrw_pkg::OP_W_DIS_ON;
               cmd.last = !more_ch;
               state_in = more_ch ? pdlrw_pkg::ST_DIS_CTL1 : pdlrw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdlrw_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != pdlrw_pkg::ST_IDLE);

   assign cmd_is_write = cmd.op inside {pdlrw_pkg::OP_W_EN_OFF, pdlrw_pkg::OP_W_EN_CTL,
                                        pdlrw_pkg::OP_W_FINAL, pdlrw_pkg::OP_W_RAMP,
                                        pdlrw_pkg::OP_W_EN_SET, pdlrw_pkg::OP_W_DIS_CTL1,
                                        pdlrw_pkg::OP_W_DIS_CTL2, pdlrw_pkg::OP_W_DIS_OFF,
                                        pdlrw_pkg::OP_W_DIS_ON};

   a_write_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd_is_write |-> status.out_free)
      else $error("register write issued while the result register is occupied");

   a_last_on_write: assert property (@(posedge clock) disable iff (reset)
      cmd.last |-> cmd_is_write)
      else $error("last-write flag raised without a write");

   a_no_ramp_while_enabling: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdlrw_pkg::ST_RAMP) |-> !phase_ff)
      else $error("ramp entered during the enable sequence");

endmodule

>>> design/pdlrw_datapath.sv
// Datapath of the PWM duty-level ramp writer: settings, channel state, level arithmetic and result register.
module pdlrw_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_action,
   input  logic                                 req_channel,
   input  logic [7:0]                           req_duty_percent,
   input  logic                                 csr_write_enable,
   input  logic [pdlrw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pdlrw_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic                                 rsp_target_block,
   output logic [7:0]                           rsp_reg_address,
   output logic [7:0]                           rsp_write_data,
   output logic                                 rsp_last_write,
   input  pdlrw_pkg::dp_cmd_type                cmd,
   output pdlrw_pkg::dp_status_type             status
);

   // Settings.
   logic [6:0] max_first_ff, max_first_in, min_first_ff, min_first_in;
   logic [6:0] max_second_ff, max_second_in, min_second_ff, min_second_in;
   logic [1:0] invert_ff, invert_in, long_ff, long_in;

   // Request and channel state.
   logic       act_ff, act_in, ch_ff, ch_in;
   logic [7:0] duty_ff, duty_in;
   logic [6:0] on_level_ff [2];
   logic [6:0] on_level_in [2];
   logic [1:0] en_ff, en_in;
   logic [5:0] shadow_ff, shadow_in;

   // Level arithmetic.
   logic [6:0]  mx_ff, mx_in, mn_ff, mn_in, d0_ff, d0_in;
   logic        range_full_ff, range_full_in;
   logic [13:0] prod_ff, prod_in;
   logic [6:0]  q_ff, q_in, d_ff, d_in;
   logic [7:0]  t_ff, t_in;
   logic [6:0]  cur_ff, cur_in, target_ff, target_in;
   logic [3:0]  count_ff, count_in;
   logic        up_ff, up_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_blk_ff, rsp_last_ff;
   logic [7:0] rsp_addr_ff, rsp_data_ff;

   logic        lng, inv;
   logic [6:0]  off_lvl, on_top, step;
   logic [7:0]  on_addr, off_addr;
   logic [6:0]  max_sel, min_sel, mx_calc, mn_calc, range_calc, d0_calc;
   logic [13:0] period_prod, mult_a;
   logic [26:0] recip_prod;
   logic [6:0]  win, flip, d_calc;
   logic [6:0]  held, cur_calc, lvl, lvl_lim, newl, tgt_calc, diff;
   logic [6:0]  cur_step;
   logic        wr_en, wr_blk;
   logic [7:0]  wr_addr, wr_data;

   assign lng      = long_ff[ch_ff];
   assign inv      = invert_ff[ch_ff];
   assign off_lvl  = lng ? pdlrw_pkg::OFF_LONG : pdlrw_pkg::OFF_SHORT;
   assign on_top   = lng ? pdlrw_pkg::ON_TOP_LONG : pdlrw_pkg::ON_TOP_SHORT;
   assign step     = lng ? pdlrw_pkg::STEP_LONG : pdlrw_pkg::STEP_SHORT;
   assign on_addr  = ch_ff ? pdlrw_pkg::ON_ADDR_SECOND : pdlrw_pkg::ON_ADDR_FIRST;
   assign off_addr = ch_ff ? pdlrw_pkg::OFF_ADDR_SECOND : pdlrw_pkg::OFF_ADDR_FIRST;

   // Window limits, with invalid settings corrected as the driver does.
   assign max_sel    = ch_ff ? max_second_ff : max_first_ff;
   assign min_sel    = ch_ff ? min_second_ff : min_first_ff;
   assign mx_calc    = (max_sel > pdlrw_pkg::DUTY_FULL || max_sel == 7'd0) ?
                       pdlrw_pkg::DUTY_FULL : max_sel;
   assign mn_calc    = (min_sel >= pdlrw_pkg::DUTY_FULL || min_sel >= mx_calc) ? 7'd0 : min_sel;
   assign range_calc = mx_calc - mn_calc;
   assign d0_calc    = cmd.unit_duty ? 7'd1 :
                       ((duty_ff > 8'(pdlrw_pkg::DUTY_FULL)) ? pdlrw_pkg::DUTY_FULL : duty_ff[6:0]);

   // One reciprocal multiplier divides by 100 for both the rescale and the period product.
   assign period_prod = lng ? {d_ff, 7'b0} : {1'b0, d_ff, 6'b0};
   assign mult_a      = (cmd.op == pdlrw_pkg::OP_CALC2) ? prod_ff : period_prod;
   assign recip_prod  = 27'(mult_a) * 27'(pdlrw_pkg::RECIP_100);

   assign win  = range_full_ff ? d0_ff : (mn_ff + q_ff);
   assign flip = pdlrw_pkg::DUTY_FULL - win;

   always_comb begin
      if (inv) begin
         if (flip > (pdlrw_pkg::DUTY_FULL - mn_ff)) begin
            d_calc = pdlrw_pkg::DUTY_FULL - mn_ff;
         end else if (flip < (pdlrw_pkg::DUTY_FULL - mx_ff)) begin
            d_calc = pdlrw_pkg::DUTY_FULL - mx_ff;
         end else begin
            d_calc = flip;
         end
      end else begin
         if (win > mx_ff) begin
            d_calc = mx_ff;
         end else if (win < mn_ff) begin
            d_calc = mn_ff;
         end else begin
            d_calc = win;
         end
      end
   end

   // ON level and ramp set-up.
   assign held = on_level_ff[ch_ff];
   assign cur_calc = (held < pdlrw_pkg::ON_BOTTOM) ? pdlrw_pkg::ON_BOTTOM :
                     ((held > on_top) ? on_top : held);
   assign lvl = (t_ff > {1'b0, off_lvl}) ? pdlrw_pkg::ON_BOTTOM : (off_lvl - t_ff[6:0]);
   assign lvl_lim = (lvl < pdlrw_pkg::ON_BOTTOM) ? pdlrw_pkg::ON_BOTTOM :
                    ((lvl > on_top) ? on_top : lvl);

   always_comb begin
      if (d_ff != 7'd0) begin
         if (!inv && d_ff > pdlrw_pkg::DUTY_NEAR) begin
            tgt_calc = off_lvl;
            newl     = on_top;
         end else begin
            tgt_calc = lvl_lim;
            newl     = lvl_lim;
         end
      end else begin
         tgt_calc = inv ? on_top : pdlrw_pkg::ON_BOTTOM;
         newl     = tgt_calc;
      end
   end

   assign diff     = (cur_calc > newl) ? (cur_calc - newl) : (newl - cur_calc);
   assign cur_step = up_ff ? (cur_ff + step) : (cur_ff - step);

   always_comb begin
      max_first_in  = max_first_ff;
      min_first_in  = min_first_ff;
      max_second_in = max_second_ff;
      min_second_in = min_second_ff;
      invert_in     = invert_ff;
      long_in       = long_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pdlrw_pkg::CSR_MAX_FIRST:   max_first_in  = csr_write_data;
            pdlrw_pkg::CSR_MIN_FIRST:   min_first_in  = csr_write_data;
            pdlrw_pkg::CSR_MAX_SECOND:  max_second_in = csr_write_data;
            pdlrw_pkg::CSR_MIN_SECOND:  min_second_in = csr_write_data;
            pdlrw_pkg::CSR_INVERT:      invert_in     = csr_write_data[1:0];
            pdlrw_pkg::CSR_LONG_PERIOD: long_in       = csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      act_in        = act_ff;
      ch_in         = ch_ff;
      duty_in       = duty_ff;
      on_level_in   = on_level_ff;
      en_in         = en_ff;
      shadow_in     = shadow_ff;
      mx_in         = mx_ff;
      mn_in         = mn_ff;
      d0_in         = d0_ff;
      range_full_in = range_full_ff;
      prod_in       = prod_ff;
      q_in          = q_ff;
      d_in          = d_ff;
      t_in          = t_ff;
      cur_in        = cur_ff;
      target_in     = target_ff;
      count_in      = count_ff;
      up_in         = up_ff;
      wr_en         = 1'b0;
      wr_blk        = pdlrw_pkg::BLK_LEVEL;
      wr_addr       = on_addr;
      wr_data       = 8'h00;
      unique case (cmd.op)
         pdlrw_pkg::OP_NONE: ;
         pdlrw_pkg::OP_LOAD: begin
            act_in  = req_action;
            duty_in = req_duty_percent;
            ch_in   = req_action ? !en_ff[0] : req_channel;
         end
         pdlrw_pkg::OP_CALC1: begin
            mx_in         = mx_calc;
            mn_in         = mn_calc;
            d0_in         = d0_calc;
            range_full_in = (range_calc == pdlrw_pkg::DUTY_FULL);
            prod_in       = 14'(d0_calc) * 14'(range_calc) + 14'(pdlrw_pkg::DUTY_HALF);
         end
         pdlrw_pkg::OP_CALC2: begin
            q_in = recip_prod[pdlrw_pkg::RECIP_SHIFT +: 7];
         end
         pdlrw_pkg::OP_CALC3: begin
            d_in = d_calc;
         end
         pdlrw_pkg::OP_CALC4: begin
            t_in = recip_prod[pdlrw_pkg::RECIP_SHIFT +: 8];
         end
         pdlrw_pkg::OP_CALC5: begin
            cur_in             = cur_calc;
            target_in          = tgt_calc;
            up_in              = !(cur_calc > newl);
            count_in           = lng ? diff[6:3] : diff[5:2];
            on_level_in[ch_ff] = newl;
         end
         pdlrw_pkg::OP_W_EN_OFF: begin
            wr_en   = 1'b1;
            wr_addr = off_addr;
            wr_data = {1'b0, off_lvl};
         end
         pdlrw_pkg::OP_W_EN_CTL: begin
            shadow_in = (shadow_ff & ~pdlrw_pkg::ctl_bits(ch_ff, pdlrw_pkg::CTL_ALL)) |
                        pdlrw_pkg::ctl_bits(ch_ff, pdlrw_pkg::CTL_CLK);
            wr_en     = 1'b1;
            wr_blk    = pdlrw_pkg::BLK_CONTROL;
            wr_addr   = pdlrw_pkg::CTRL_ADDR;
            wr_data   = {2'b00, shadow_in};
         end
         pdlrw_pkg::OP_W_FINAL: begin
            wr_en   = 1'b1;
            wr_data = {!lng, target_ff};
         end
         pdlrw_pkg::OP_W_RAMP: begin
            cur_in   = cur_step;
            count_in = count_ff - 4'd1;
            wr_en    = 1'b1;
            wr_data  = {!lng, cur_step};
         end
         pdlrw_pkg::OP_W_EN_SET: begin
            shadow_in    = shadow_ff | pdlrw_pkg::ctl_bits(ch_ff, pdlrw_pkg::CTL_SET);
            en_in[ch_ff] = 1'b1;
            wr_en        = 1'b1;
            wr_blk       = pdlrw_pkg::BLK_CONTROL;
            wr_addr      = pdlrw_pkg::CTRL_ADDR;
            wr_data      = {2'b00, shadow_in};
         end
         pdlrw_pkg::OP_W_DIS_CTL1: begin
            shadow_in    = (shadow_ff & ~pdlrw_pkg::ctl_bits(ch_ff, pdlrw_pkg::CTL_SET)) |
                           pdlrw_pkg::ctl_bits(ch_ff, pdlrw_pkg::CTL_RST);
            en_in[ch_ff] = 1'b0;
            wr_en        = 1'b1;
            wr_blk       = pdlrw_pkg::BLK_CONTROL;
            wr_addr      = pdlrw_pkg::CTRL_ADDR;
            wr_data      = {2'b00, shadow_in};
         end
         pdlrw_pkg::OP_W_DIS_CTL2: begin
            shadow_in = shadow_ff & ~pdlrw_pkg::ctl_bits(ch_ff, pdlrw_pkg::CTL_ALL);
            wr_en     = 1'b1;
            wr_blk    = pdlrw_pkg::BLK_CONTROL;
            wr_addr   = pdlrw_pkg::CTRL_ADDR;
            wr_data   = {2'b00, shadow_in};
         end
         pdlrw_pkg::OP_W_DIS_OFF: begin
            wr_en   = 1'b1;
            wr_addr = off_addr;
            wr_data = 8'(off_lvl) + 8'd1;
         end
         pdlrw_pkg::OP_W_DIS_ON: begin
            // A shutdown moves on to the second channel once the first is done.
            if (act_ff) begin
               ch_in = 1'b1;
            end
            wr_en   = 1'b1;
            wr_data = 8'h00;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = wr_en ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_first_ff   <= pdlrw_pkg::DUTY_FULL;
         min_first_ff   <= 7'd0;
         max_second_ff  <= pdlrw_pkg::DUTY_FULL;
         min_second_ff  <= 7'd0;
         invert_ff      <= 2'b00;
         long_ff        <= 2'b11;
         on_level_ff[0] <= pdlrw_pkg::ON_BOTTOM;
         on_level_ff[1] <= pdlrw_pkg::ON_BOTTOM;
         en_ff          <= 2'b00;
         shadow_ff      <= 6'd0;
         act_ff         <= 1'b0;
         ch_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_first_ff  <= max_first_in;
         min_first_ff  <= min_first_in;
         max_second_ff <= max_second_in;
         min_second_ff <= min_second_in;
         invert_ff     <= invert_in;
         long_ff       <= long_in;
         on_level_ff   <= on_level_in;
         en_ff         <= en_in;
         shadow_ff     <= shadow_in;
         act_ff        <= act_in;
         ch_ff         <= ch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      duty_ff       <= duty_in;
      mx_ff         <= mx_in;
      mn_ff         <= mn_in;
      d0_ff         <= d0_in;
      range_full_ff <= range_full_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      d_ff          <= d_in;
      t_ff          <= t_in;
      cur_ff        <= cur_in;
      target_ff     <= target_in;
      count_ff      <= count_in;
      up_ff         <= up_in;
      if (wr_en) begin
         rsp_blk_ff  <= wr_blk;
         rsp_addr_ff <= wr_addr;
         rsp_data_ff <= wr_data;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_block = rsp_blk_ff;
   assign rsp_reg_address  = rsp_addr_ff;
   assign rsp_write_data   = rsp_data_ff;
   assign rsp_last_write   = rsp_last_ff;

   assign status.act        = act_ff;
   assign status.duty_zero  = (duty_ff == 8'd0);
   assign status.ch         = ch_ff;
   assign status.en         = en_ff;
   assign status.count_zero = (count_ff == 4'd0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   a_ramp_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pdlrw_pkg::OP_W_RAMP) |=>
         (cur_ff >= pdlrw_pkg::ON_BOTTOM && cur_ff <= pdlrw_pkg::ON_TOP_LONG))
      else $error("ramp level left the legal ON range");

   a_level_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pdlrw_pkg::OP_CALC5) |=> (on_level_ff[ch_ff] != 7'd0))
      else $error("held ON level became zero");

   a_enabled_shadow: assert property (@(posedge clock) disable iff (reset)
      (!en_ff[0] || shadow_ff[2:0] == (pdlrw_pkg::CTL_CLK | pdlrw_pkg::CTL_SET)) &&
      (!en_ff[1] || shadow_ff[5:3] == (pdlrw_pkg::CTL_CLK | pdlrw_pkg::CTL_SET)))
      else $error("enabled channel without clock and set bits in the control image");

endmodule
